// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/vern_pkg.sv -----
// Types, constants and arithmetic helpers of the vertical edge row filter.
`timescale 1ns / 1ps
`default_nettype none

package vern_pkg;

	localparam int PIX_W    = 8;
	localparam int WEIGHT_W = PIX_W + 2;
	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW    = $clog2(CMD_DEPTH);
	localparam int OUT_DEPTH = 2;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);

	typedef struct packed {
		logic [PIX_W-1:0] pixel_above;
		logic [PIX_W-1:0] pixel_centre;
		logic [PIX_W-1:0] pixel_below;
		logic             row_end;
	} col_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] edge_value;
		logic             row_last;
	} edge_out_t;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_THIRD,
		PH_LATER
	} phase_t;

	typedef enum logic [2:0] {
		CMD_SINGLE,
		CMD_PAIR,
		CMD_LOAD,
		CMD_FIRST,
		CMD_INNER
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic             row_end;
		logic [PIX_W-1:0] fa;
		logic [PIX_W-1:0] fb;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	localparam logic [1:0] STEP_FIRST  = 2'd0;
	localparam logic [1:0] STEP_SECOND = 2'd1;
	localparam logic [1:0] STEP_THIRD  = 2'd2;

	function automatic logic [WEIGHT_W-1:0] column_weight(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
		return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
	endfunction

	function automatic logic [PIX_W-1:0] grad_clamp(input logic [WEIGHT_W-1:0] right_w,
		input logic [WEIGHT_W-1:0] left_w);
		logic [WEIGHT_W-1:0] d;
		d = right_w - left_w;
		if (right_w <= left_w)
			return '0;
		else if (d > WEIGHT_W'({PIX_W{1'b1}}))
			return '1;
		else
			return d[PIX_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] suppress(input logic [PIX_W-1:0] cur,
		input logic [PIX_W-1:0] left, input logic [PIX_W-1:0] right);
		if (cur < left || cur <= right)
			return '0;
		else
			return cur;
	endfunction

endpackage

`default_nettype wire

// ----- src/vern_front.sv -----
// Front end: takes columns, runs the Sobel weights and classifies columns into commands.
`timescale 1ns / 1ps
`default_nettype none

module vern_front
	import vern_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire col_in_t   column,
	input  wire q_status_t cmd_status,
	output logic           cmd_push,
	output cmd_t           cmd
);

	phase_t              phase_q;
	logic [WEIGHT_W-1:0] w1_q;
	logic [WEIGHT_W-1:0] w2_q;
	logic [WEIGHT_W-1:0] w_cur;
	logic                take;

	assign full  = cmd_status.full;
	assign take  = push && !cmd_status.full;
	assign w_cur = column_weight(column.pixel_above, column.pixel_centre, column.pixel_below);

	always_comb begin
		cmd.row_end = column.row_end;
		cmd.fb      = grad_clamp(w_cur, w1_q);
		cmd.fa      = grad_clamp(w_cur, w2_q);
		cmd_push    = take;
		unique case (phase_q)
			PH_FIRST: begin
				cmd.kind = CMD_SINGLE;
				// a lone first column only yields a result when it also ends the row
				cmd_push = take && column.row_end;
			end
			PH_SECOND: begin
				cmd.kind = column.row_end ? CMD_PAIR : CMD_LOAD;
				cmd.fa   = grad_clamp(w_cur, w1_q);
			end
			PH_THIRD: cmd.kind = CMD_FIRST;
			PH_LATER: cmd.kind = CMD_INNER;
			default:  cmd.kind = CMD_INNER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			w1_q    <= '0;
			w2_q    <= '0;
		end else if (take) begin
			w2_q <= w1_q;
			w1_q <= w_cur;
			if (column.row_end) begin
				phase_q <= PH_FIRST;
			end else begin
				unique case (phase_q)
					PH_FIRST:  phase_q <= PH_SECOND;
					PH_SECOND: phase_q <= PH_THIRD;
					PH_THIRD:  phase_q <= PH_LATER;
					PH_LATER:  phase_q <= PH_LATER;
					default:   phase_q <= PH_FIRST;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/vern_cmd_queue.sv -----
// Command queue between the front end and the suppression back end.
`timescale 1ns / 1ps
`default_nettype none

module vern_cmd_queue
	import vern_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire cmd_t  wr_data,
	input  wire logic  rd_en,
	output cmd_t       head,
	output q_status_t  status
);

	cmd_t            mem_q [CMD_DEPTH];
	logic [CMD_AW:0] wr_ptr_q;
	logic [CMD_AW:0] rd_ptr_q;

	assign status.empty = (wr_ptr_q == rd_ptr_q);
	assign status.full  = (wr_ptr_q[CMD_AW] != rd_ptr_q[CMD_AW])
		&& (wr_ptr_q[CMD_AW-1:0] == rd_ptr_q[CMD_AW-1:0]);
	assign head = mem_q[rd_ptr_q[CMD_AW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en && !status.full)
			mem_q[wr_ptr_q[CMD_AW-1:0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en && !status.full)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en && !status.empty)
				rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- src/vern_back.sv -----
// Back end: runs row suppression on queued commands and buffers the results.
`timescale 1ns / 1ps
`default_nettype none

module vern_back
	import vern_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cmd_t      head,
	input  wire q_status_t cmd_status,
	output logic           cmd_pop,
	output edge_out_t      result,
	output logic           empty,
	input  wire logic      pop,
	output logic [1:0]     step
);

	logic [1:0]       step_q;
	logic [PIX_W-1:0] pending_q;
	logic [PIX_W-1:0] left_q;
	edge_out_t        out_mem_q [OUT_DEPTH];
	logic [OUT_AW:0]  out_wr_q;
	logic [OUT_AW:0]  out_rd_q;
	logic             out_full;
	logic             emits;
	logic             last;
	logic             go;
	edge_out_t        res;
	logic [PIX_W-1:0] o_val;

	assign step     = step_q;
	assign empty    = (out_wr_q == out_rd_q);
	assign out_full = (out_wr_q[OUT_AW] != out_rd_q[OUT_AW])
		&& (out_wr_q[OUT_AW-1:0] == out_rd_q[OUT_AW-1:0]);
	assign result   = out_mem_q[out_rd_q[OUT_AW-1:0]];

	always_comb begin
		emits = 1'b1;
		last  = 1'b1;
		o_val = '0;
		res   = '{edge_value: '0, row_last: 1'b0};
		unique case (head.kind)
			CMD_SINGLE: res = '{edge_value: '0, row_last: 1'b1};
			CMD_PAIR: begin
				last = (step_q == STEP_SECOND);
				res  = '{edge_value: head.fa, row_last: last};
			end
			CMD_LOAD: emits = 1'b0;
			CMD_FIRST, CMD_INNER: begin
				last = !head.row_end || (step_q == STEP_THIRD);
				priority case (step_q)
					STEP_FIRST: begin
						o_val = (head.kind == CMD_FIRST) ? pending_q
							: suppress(pending_q, left_q, head.fa);
						res = '{edge_value: o_val, row_last: 1'b0};
					end
					STEP_SECOND: begin
						// pending now holds the second-to-last column's value
						o_val = suppress(pending_q, left_q, head.fb);
						res   = '{edge_value: o_val, row_last: 1'b0};
					end
					default: res = '{edge_value: head.fb, row_last: 1'b1};
				endcase
			end
			default: emits = 1'b0;
		endcase
		go      = !cmd_status.empty && (!emits || !out_full);
		cmd_pop = go && last;
	end

	always_ff @(posedge clk) begin
		if (go && emits)
			out_mem_q[out_wr_q[OUT_AW-1:0]] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_FIRST;
			pending_q <= '0;
			left_q    <= '0;
			out_wr_q  <= '0;
			out_rd_q  <= '0;
		end else begin
			if (go) begin
				step_q <= last ? STEP_FIRST : step_q + 1'b1;
				if (head.kind == CMD_LOAD)
					pending_q <= head.fa;
				if ((head.kind == CMD_FIRST || head.kind == CMD_INNER)
					&& step_q != STEP_THIRD) begin
					left_q <= o_val;
					if (step_q == STEP_FIRST)
						pending_q <= head.fa;
				end
			end
			if (go && emits)
				out_wr_q <= out_wr_q + 1'b1;
			if (pop && !empty)
				out_rd_q <= out_rd_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- src/vertical_edge_row_nms.sv -----
// Top level of the vertical edge filter with row non-maximum suppression.
// Usage:
//   Input queue side: drive column (three stacked gray pixels and row_end) with push;
//   the column is taken at a clock edge with push high and full low.
//   Result queue side: while empty is low, result holds the oldest edge value and its
//   row_last flag; it is taken at a clock edge with pop high and empty low.
// Throughput: one column per clock while full is low. The front end computes weights and
// gradients in the cycle a column is taken and drops a command into a four-entry queue;
// the back end writes one result per step while the result buffer has room (one to
// three results per command), plus a step with no result for the command of a row's
// second column. Results trail the input by two columns: a column's result is written
// by the command of the column two places to its right; a row_end column releases up
// to three.
// The three-result burst at row end drains through the command queue while input keeps
// flowing; full rises only when the queue fills.
// Reset: arst_n clears both queues, the column history and phase; the next column
// taken starts a new row.
// Stall: when pop stays low the two-entry result buffer fills, the back end halts, the
// command queue fills and full rises; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vertical_edge_row_nms
	import vern_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	output logic         full,
	input  wire col_in_t column,
	output logic         empty,
	input  wire logic    pop,
	output edge_out_t    result
);

	q_status_t  cmd_status;
	logic       cmd_push;
	logic       cmd_pop;
	cmd_t       cmd_in;
	cmd_t       cmd_head;
	logic [1:0] back_step;

	vern_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.column     (column),
		.cmd_status (cmd_status),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	vern_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.head    (cmd_head),
		.status  (cmd_status)
	);

	vern_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (cmd_head),
		.cmd_status (cmd_status),
		.cmd_pop    (cmd_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop),
		.step       (back_step)
	);

	`ASSERT_IMPLY(a_step_needs_cmd, clk, arst_n, back_step != STEP_FIRST, !cmd_status.empty)
	`ASSERT_NEXT(a_row_end_queues, clk, arst_n, push && !full && column.row_end, !cmd_status.empty)
	`ASSERT_NEXT(a_idle_step_clear, clk, arst_n, cmd_status.empty, back_step == STEP_FIRST)

endmodule

`default_nettype wire
